[sv/iwi_pkg.sv]
// ----------------------------------------------------------------------------
// iwi_pkg: shared types, constants and bit permutations
// Whitening constant, operating modes, result bundle and the lane shuffle
// used by the index whiten/interleave unit.
// ----------------------------------------------------------------------------
package iwi_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned PosW  = 6;

  localparam logic [WordW-1:0] WhiteConst   = 64'h93cb_c407_7efd_dc15;
  localparam logic [PosW-1:0]  IndexBitsRst = 6'd32;

  typedef enum logic {
    MODE_ENCODE = 1'b0,
    MODE_DECODE = 1'b1
  } mode_t;

  typedef struct packed {
    logic [WordW-1:0] index_out;
    logic             valid_res;
  } result_t;

  // Bit i lands on 2*i for the low half and 2*(i-32)+1 for the high half.
  function automatic logic [PosW-1:0] lane_pos(input logic [PosW-1:0] i);
    return {i[PosW-2:0], i[PosW-1]};
  endfunction

  function automatic logic [WordW-1:0] interleave(input logic [WordW-1:0] x);
    logic [WordW-1:0] r;
    r = '0;
    for (int i = 0; i < WordW; i++) begin
      r[lane_pos(PosW'(i))] = x[i];
    end
    return r;
  endfunction

  function automatic logic [WordW-1:0] deinterleave(input logic [WordW-1:0] x);
    logic [WordW-1:0] r;
    r = '0;
    for (int i = 0; i < WordW; i++) begin
      r[i] = x[lane_pos(PosW'(i))];
    end
    return r;
  endfunction

endpackage

[sv/index_whiten_interleave_unit.sv]
// ----------------------------------------------------------------------------
// index_whiten_interleave_unit: index encoder and checker
// Pipeline: each transaction is registered in the input stage, then in the result stage.
// Throughput: one transaction per cycle while out_stall is low, set by the single-pass
//   whitening XOR network between the input and result registers.
// Reset (rst_n, synchronous, active low): both stages empty, index_bits = 32.
// ----------------------------------------------------------------------------
module index_whiten_interleave_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_mode,
  input  logic [iwi_pkg::WordW-1:0]  in_index_in,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [iwi_pkg::WordW-1:0]  out_index_out,
  output logic                       out_valid_res,
  // configuration
  input  logic                       cfg_wr_en,
  input  logic [iwi_pkg::PosW-1:0]   cfg_wr_data
);

  // Configuration: width of the raw index field.
  logic [iwi_pkg::PosW-1:0]  index_bits_r;

  // Input stage.
  logic                      s1_valid_r, s1_valid_nxt;
  logic                      s1_mode_r;
  logic [iwi_pkg::WordW-1:0] s1_index_r;

  // Result stage.
  logic                      out_valid_r, out_valid_nxt;
  iwi_pkg::result_t          out_res_r;

  iwi_pkg::result_t          res;
  logic                      out_open;
  logic                      s1_open;
  logic                      in_take;

  // The result register frees up when empty or when its transaction leaves.
  assign out_open = !out_valid_r || !out_stall;
  // The input register frees up when empty or when it moves forward.
  assign s1_open  = !s1_valid_r || out_open;
  assign in_stall = !s1_open;
  assign in_take  = in_valid && s1_open;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_bits_r <= iwi_pkg::IndexBitsRst;
    end else if (cfg_wr_en) begin
      index_bits_r <= cfg_wr_data;
    end
  end

  // Advance the input stage; hold it while the result side is stalled.
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (s1_open) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_mode_r  <= in_mode;
      s1_index_r <= in_index_in;
    end
  end

  // All whitening, shifting and permutation happens here in one pass.
  iwi_core u_core (
    .mode       (s1_mode_r),
    .index_in   (s1_index_r),
    .index_bits (index_bits_r),
    .res        (res)
  );

  // Load the result register whenever it is open; drop it once taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_open) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open && s1_valid_r) begin
      out_res_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_index_out = out_res_r.index_out;
  assign out_valid_res = out_res_r.valid_res;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // Backpressure only when both stages are full.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled while a stage is free");

  // A stalled input stage keeps its transaction.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && in_stall) |=> (s1_valid_r && $stable(s1_index_r)))
    else $error("input stage lost a transaction under stall");

  // Encode always reports a valid word.
  a_encode_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_mode_r == iwi_pkg::MODE_ENCODE) |-> res.valid_res)
    else $error("encode result flagged invalid");

  // A decoded index never has bits above the index field.
  a_decode_masked: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && s1_mode_r == iwi_pkg::MODE_DECODE)
      |-> ((res.index_out >> index_bits_r) == '0))
    else $error("decoded index exceeds the index field");

endmodule

[sv/iwi_whiten.sv]
// ----------------------------------------------------------------------------
// iwi_whiten: whitening XOR network
// Carry-less multiply of the operand by the whitening constant modulo
// x^64+1; each output bit is the parity of one AND-masked term vector.
// ----------------------------------------------------------------------------
module iwi_whiten (
  input  logic [iwi_pkg::WordW-1:0] op,
  output logic [iwi_pkg::WordW-1:0] white
);

  logic [iwi_pkg::WordW-1:0] terms [iwi_pkg::WordW];

  // Output bit j collects constant bit (j-k) mod 64 for every set operand bit k.
  always_comb begin
    for (int j = 0; j < iwi_pkg::WordW; j++) begin
      for (int k = 0; k < iwi_pkg::WordW; k++) begin
        terms[j][k] = op[k] & iwi_pkg::WhiteConst[iwi_pkg::PosW'(j - k)];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < iwi_pkg::WordW; j++) begin
      white[j] = ^terms[j];
    end
  end

endmodule

[sv/iwi_core.sv]
// ----------------------------------------------------------------------------
// iwi_core: encode / decode datapath
// Selects the whitening operand, shifts the whitening above the index
// field, then interleaves (encode) or masks and checks (decode).
// ----------------------------------------------------------------------------
module iwi_core (
  input  logic                       mode,
  input  logic [iwi_pkg::WordW-1:0]  index_in,
  input  logic [iwi_pkg::PosW-1:0]   index_bits,
  output iwi_pkg::result_t           res
);

  logic                      is_decode;
  logic [iwi_pkg::WordW-1:0] mask;
  logic [iwi_pkg::WordW-1:0] ind;
  logic [iwi_pkg::WordW-1:0] idx;
  logic [iwi_pkg::WordW-1:0] op;
  logic [iwi_pkg::WordW-1:0] white;
  logic [iwi_pkg::WordW-1:0] white_sh;

  assign is_decode = (mode == iwi_pkg::MODE_DECODE);
  assign mask      = ~({iwi_pkg::WordW{1'b1}} << index_bits);
  assign ind       = iwi_pkg::deinterleave(index_in);
  assign idx       = ind & mask;
  assign op        = is_decode ? idx : index_in;

  iwi_whiten u_whiten (
    .op    (op),
    .white (white)
  );

  assign white_sh = white << index_bits;

  always_comb begin
    if (is_decode) begin
      res.index_out = idx;
      res.valid_res = (white_sh == (ind & ~mask));
    end else begin
      // raw input goes in unmasked
      res.index_out = iwi_pkg::interleave(white_sh | index_in);
      res.valid_res = 1'b1;
    end
  end

endmodule
